[design/ithb_pkg.sv]
`default_nettype none

package ithb_pkg;

    // Input protocol codes
    localparam logic [1:0] PROTO_TCP    = 2'd0;
    localparam logic [1:0] PROTO_UDP    = 2'd1;
    localparam logic [1:0] PROTO_ICMP   = 2'd2;
    localparam logic [1:0] PROTO_UNUSED = 2'd3;

    // IPv4 protocol numbers
    localparam logic [7:0] IP_PROTO_TCP  = 8'd6;
    localparam logic [7:0] IP_PROTO_UDP  = 8'd17;
    localparam logic [7:0] IP_PROTO_ICMP = 8'd1;

    // Frame layout
    localparam logic [15:0] HDR_LEN   = 16'd54;
    localparam logic [15:0] ETH_LEN   = 16'd14;
    localparam logic [15:0] L4_OFF    = 16'd34;
    localparam logic [15:0] ETHERTYPE = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL = 8'h45;

    // Layer four constants
    localparam logic [15:0] TCP_WINDOW    = 16'hFFFF;
    localparam logic [7:0]  TCP_DATA_OFF  = 8'h50;
    localparam logic [7:0]  TCP_FLAG_SYN  = 8'h02;
    localparam logic [7:0]  ICMP_ECHO_REQ = 8'h08;
    localparam logic [15:0] ICMP_CSUM     = 16'hF7FF;

    // Beat sequencing
    localparam logic [2:0] LAST_BEAT  = 3'd6;
    localparam logic [3:0] FULL_BYTES = 4'd8;
    localparam logic [3:0] LAST_BYTES = 4'd6;

    // Unfolded IPv4 header sum: seven 16-bit terms
    localparam int SUM_W = 19;

    typedef enum logic [1:0] {
        L4_TCP  = 2'd0,
        L4_UDP  = 2'd1,
        L4_ICMP = 2'd2
    } l4_kind_t;

    typedef struct packed {
        logic [15:0]      flen;
        l4_kind_t         kind;
        logic [7:0]       ttl;
        logic [31:0]      sip;
        logic [31:0]      dip;
        logic [15:0]      sport;
        logic [15:0]      dport;
        logic [SUM_W-1:0] hdr_sum;
    } desc_t;

endpackage

`default_nettype wire

[design/ithb_front.sv]
`default_nettype none

module ithb_front
(
    input  wire logic [15:0]    frame_size,
    input  wire logic [1:0]     protocol,
    input  wire logic [7:0]     ttl,
    input  wire logic [31:0]    source_ip,
    input  wire logic [31:0]    dest_ip,
    input  wire logic [15:0]    source_port,
    input  wire logic [15:0]    dest_port,
    output ithb_pkg::desc_t     desc
);
    import ithb_pkg::*;

    logic [15:0]      flen;
    logic [15:0]      tot_len;
    logic [7:0]       ip_proto;
    l4_kind_t         kind;
    logic [SUM_W-1:0] sum;

    // Clamp to the minimum header length
    assign flen    = (frame_size < HDR_LEN) ? HDR_LEN : frame_size;
    assign tot_len = flen - ETH_LEN;

    always_comb
    begin
        unique case (protocol)
            PROTO_UDP:
            begin
                kind     = L4_UDP;
                ip_proto = IP_PROTO_UDP;
            end
            PROTO_ICMP:
            begin
                kind     = L4_ICMP;
                ip_proto = IP_PROTO_ICMP;
            end
            default:
            begin
                // TCP and the unused code both build a SYN
                kind     = L4_TCP;
                ip_proto = IP_PROTO_TCP;
            end
        endcase
    end

    // Nonzero IPv4 header words; fold and invert happen in the back end
    assign sum = SUM_W'({IP_VER_IHL, 8'h00})
               + SUM_W'(tot_len)
               + SUM_W'({ttl, ip_proto})
               + SUM_W'(source_ip[31:16])
               + SUM_W'(source_ip[15:0])
               + SUM_W'(dest_ip[31:16])
               + SUM_W'(dest_ip[15:0]);

    always_comb
    begin
        desc.flen    = flen;
        desc.kind    = kind;
        desc.ttl     = ttl;
        desc.sip     = source_ip;
        desc.dip     = dest_ip;
        desc.sport   = source_port;
        desc.dport   = dest_port;
        desc.hdr_sum = sum;
    end

endmodule

`default_nettype wire

[design/ithb_queue.sv]
`default_nettype none

module ithb_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  ithb_pkg::desc_t     push_desc,
    output logic                full,
    input  wire logic           pop,
    output ithb_pkg::desc_t     head,
    output logic                empty
);
    import ithb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue popped while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

`default_nettype wire

[design/ithb_back.sv]
`default_nettype none

module ithb_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [47:0]    source_mac,
    input  ithb_pkg::desc_t     head,
    input  wire logic           empty,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [63:0]         beat_data,
    output logic [3:0]          beat_bytes,
    output logic                last_beat,
    output logic [15:0]         frame_length
);
    import ithb_pkg::*;

    localparam logic [2:0] BEAT_ETH_DST = 3'd0;
    localparam logic [2:0] BEAT_ETH_SRC = 3'd1;
    localparam logic [2:0] BEAT_IP_LEN  = 3'd2;
    localparam logic [2:0] BEAT_IP_ADDR = 3'd3;
    localparam logic [2:0] BEAT_L4_PORT = 3'd4;
    localparam logic [2:0] BEAT_L4_MID  = 3'd5;

    logic        out_valid_reg;
    logic [63:0] beat_data_reg;
    logic [3:0]  beat_bytes_reg;
    logic        last_beat_reg;
    logic [15:0] frame_length_reg;
    logic [2:0]  beat_reg;
    logic [2:0]  beat_next;

    logic        load;
    logic        is_last;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] ip_csum;
    logic [15:0] tot_len;
    logic [15:0] udp_len;
    logic [7:0]  ip_proto;
    logic [63:0] word;

    assign load    = !empty && (!out_valid_reg || out_ready);
    assign is_last = (beat_reg == LAST_BEAT);
    assign pop     = load && is_last;
    assign beat_next = is_last ? '0 : beat_reg + 1'b1;

    // End-around carry fold of the header sum
    assign fold1   = 17'(head.hdr_sum[15:0]) + 17'(head.hdr_sum[SUM_W-1:16]);
    assign fold2   = fold1[15:0] + 16'(fold1[16]);
    assign ip_csum = ~fold2;

    assign tot_len = head.flen - ETH_LEN;
    assign udp_len = head.flen - L4_OFF;

    always_comb
    begin
        unique case (head.kind)
            L4_UDP:  ip_proto = IP_PROTO_UDP;
            L4_ICMP: ip_proto = IP_PROTO_ICMP;
            default: ip_proto = IP_PROTO_TCP;
        endcase
    end

    always_comb
    begin
        word = '0;
        unique case (beat_reg)
            BEAT_ETH_DST: word = {48'hFFFF_FFFF_FFFF, source_mac[47:32]};
            BEAT_ETH_SRC: word = {source_mac[31:0], ETHERTYPE, IP_VER_IHL, 8'h00};
            BEAT_IP_LEN:  word = {tot_len, 32'h0, head.ttl, ip_proto};
            BEAT_IP_ADDR: word = {ip_csum, head.sip, head.dip[31:16]};
            BEAT_L4_PORT:
            begin
                case (head.kind)
                    L4_UDP:  word = {head.dip[15:0], head.sport, head.dport, udp_len};
                    L4_ICMP: word = {head.dip[15:0], ICMP_ECHO_REQ, 8'h00, ICMP_CSUM, 16'h0};
                    default: word = {head.dip[15:0], head.sport, head.dport, 16'h0};
                endcase
            end
            BEAT_L4_MID:
            begin
                if (head.kind == L4_TCP)
                    word = {48'h0, TCP_DATA_OFF, TCP_FLAG_SYN};
            end
            default:
            begin
                if (head.kind == L4_TCP)
                    word = {TCP_WINDOW, 48'h0};
            end
        endcase
    end

    // Payload of the output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_data_reg    <= word;
            beat_bytes_reg   <= is_last ? LAST_BYTES : FULL_BYTES;
            last_beat_reg    <= is_last;
            frame_length_reg <= head.flen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            beat_reg      <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                beat_reg      <= beat_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign beat_data    = beat_data_reg;
    assign beat_bytes   = beat_bytes_reg;
    assign last_beat    = last_beat_reg;
    assign frame_length = frame_length_reg;

    assert property (@(posedge clk) disable iff (!rst_n) beat_reg <= LAST_BEAT)
        else $error("beat counter out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (beat_reg == '0) && out_valid_reg && last_beat_reg)
        else $error("frame end did not restart the beat counter");

endmodule

`default_nettype wire

[design/ipv4_test_frame_header_builder.sv]
`default_nettype none

// IPv4 test frame header builder. Each packet description transferred on the
// input channel (size, protocol, TTL, addresses, ports) produces the 54-byte
// header of a traffic-generator frame as seven 64-bit beats in wire order,
// first wire byte in the most significant lane. Beats 0 to 5 carry 8 valid
// bytes; beat 6 carries 6 and has last_beat set. frame_length is the
// requested size raised to at least 54 and repeats on every beat. The header
// is a broadcast Ethernet header from source_mac with ethertype IPv4, an
// IPv4 header with computed checksum, and a TCP SYN (window 65535, checksum
// 0), UDP (checksum 0) or ICMP echo request header; protocol code 3 builds
// TCP. Payload bytes are not emitted. source_mac is written by a single
// cycle pulse on source_mac_we and should change only while the block is
// idle. The output beat sequencer emits one beat per cycle while out_ready
// allows, one description at a time. The front end classifies a description
// and starts the IPv4 checksum in the cycle of its transfer and places it in
// a QUEUE_DEPTH entry queue, so in_ready stays high while the queue has room
// even if the output is stalled. The first beat is registered at the output
// once the description has been written into the queue.
module ipv4_test_frame_header_builder
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,

    // Configuration
    input  wire logic           source_mac_we,
    input  wire logic [47:0]    source_mac,

    // Packet description channel
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [15:0]    frame_size,
    input  wire logic [1:0]     protocol,
    input  wire logic [7:0]     ttl,
    input  wire logic [31:0]    source_ip,
    input  wire logic [31:0]    dest_ip,
    input  wire logic [15:0]    source_port,
    input  wire logic [15:0]    dest_port,

    // Header beat channel
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [63:0]         beat_data,
    output logic [3:0]          beat_bytes,
    output logic                last_beat,
    output logic [15:0]         frame_length
);
    import ithb_pkg::*;

    logic [47:0] source_mac_reg;
    desc_t       front_desc;
    desc_t       head_desc;
    logic        queue_full;
    logic        queue_empty;
    logic        queue_pop;
    logic        push;

    // Hold the source MAC until the next write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            source_mac_reg <= '0;
        else if (source_mac_we)
            source_mac_reg <= source_mac;
    end

    // Accept whenever the queue has room
    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    ithb_front u_front
    (
        .frame_size   (frame_size),
        .protocol     (protocol),
        .ttl          (ttl),
        .source_ip    (source_ip),
        .dest_ip      (dest_ip),
        .source_port  (source_port),
        .dest_port    (dest_port),
        .desc         (front_desc)
    );

    ithb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (front_desc),
        .full      (queue_full),
        .pop       (queue_pop),
        .head      (head_desc),
        .empty     (queue_empty)
    );

    // Advance one header beat per cycle from the queue head while out_ready allows
    ithb_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_mac   (source_mac_reg),
        .head         (head_desc),
        .empty        (queue_empty),
        .pop          (queue_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .beat_data    (beat_data),
        .beat_bytes   (beat_bytes),
        .last_beat    (last_beat),
        .frame_length (frame_length)
    );

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    import ithb_pkg::*;

    // Cycles to wait after the last expected beat before touching source_mac
    // or ending the run.
    localparam int SETTLE_CYCLES = 12;

    // Watchdog: well above the slowest legal run. That run is about 400
    // descriptions, seven beats each, every beat held by the longest stall.
    localparam longint RUN_LIMIT_NS = 64'd4_000_000;

    // One packet description as presented on the input channel
    typedef struct packed {
        logic [15:0] frame_size;
        logic [1:0]  protocol;
        logic [7:0]  ttl;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
    } pkt_desc_t;

    // One header beat as seen on the output channel
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  bytes;
        logic        last;
        logic [15:0] flen;
    } hdr_beat_t;

    // Holds the expected header beats of every accepted description, in
    // order, and checks each beat that leaves the block against the oldest.
    class frame_header_ledger;
        logic [47:0] mac;
        hdr_beat_t   expected_beats[$];
        int          errors;

        function new();
            mac    = '0;
            errors = 0;
        endfunction

        function void set_mac(logic [47:0] value);
            mac = value;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // Build the 54-byte header of one description and queue its seven beats.
        function void note_description(pkt_desc_t p);
            logic [7:0]  hdr [0:55];
            logic [15:0] flen;
            logic [7:0]  ip_proto;
            logic [31:0] acc;
            hdr_beat_t   b;
            int          i;
            int          k;

            flen = (p.frame_size < HDR_LEN) ? HDR_LEN : p.frame_size;
            for (i = 0; i < 56; i++)
                hdr[i] = 8'h00;

            // Ethernet: broadcast destination, configured source, IPv4 type
            for (i = 0; i < 6; i++)
            begin
                hdr[i]     = 8'hFF;
                hdr[6 + i] = mac[47 - 8 * i -: 8];
            end
            {hdr[12], hdr[13]} = ETHERTYPE;

            // IPv4 header, checksum filled in once the protocol is known
            hdr[14]            = IP_VER_IHL;
            {hdr[16], hdr[17]} = flen - ETH_LEN;
            hdr[22]            = p.ttl;
            {hdr[26], hdr[27], hdr[28], hdr[29]} = p.sip;
            {hdr[30], hdr[31], hdr[32], hdr[33]} = p.dip;

            case (p.protocol)
                PROTO_UDP:
                begin
                    ip_proto           = IP_PROTO_UDP;
                    {hdr[34], hdr[35]} = p.sport;
                    {hdr[36], hdr[37]} = p.dport;
                    {hdr[38], hdr[39]} = flen - L4_OFF;
                end
                PROTO_ICMP:
                begin
                    ip_proto           = IP_PROTO_ICMP;
                    hdr[34]            = ICMP_ECHO_REQ;
                    {hdr[36], hdr[37]} = ICMP_CSUM;
                end
                default:
                begin
                    // TCP SYN, also for the unused protocol code
                    ip_proto           = IP_PROTO_TCP;
                    {hdr[34], hdr[35]} = p.sport;
                    {hdr[36], hdr[37]} = p.dport;
                    hdr[46]            = TCP_DATA_OFF;
                    hdr[47]            = TCP_FLAG_SYN;
                    {hdr[48], hdr[49]} = TCP_WINDOW;
                end
            endcase
            hdr[23] = ip_proto;

            // Ones' complement sum over the IPv4 header, checksum field zero
            acc = '0;
            for (i = 14; i < 34; i += 2)
                acc += {16'h0000, hdr[i], hdr[i + 1]};
            while (acc[31:16] != 16'h0000)
                acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
            {hdr[24], hdr[25]} = ~acc[15:0];

            for (k = 0; k < 7; k++)
            begin
                b.data = '0;
                for (i = 0; i < 8; i++)
                    b.data = {b.data[55:0], hdr[8 * k + i]};
                b.bytes = (k == LAST_BEAT) ? LAST_BYTES : FULL_BYTES;
                b.last  = (k == LAST_BEAT);
                b.flen  = flen;
                expected_beats = {expected_beats, b};
            end
        endfunction

        function void check_beat(logic [63:0] data, logic [3:0] bytes,
                                 logic last, logic [15:0] flen);
            hdr_beat_t want;

            if (expected_beats.size() == 0)
            begin
                $error("unexpected beat: data %h bytes %0d last %0b length %0d",
                       data, bytes, last, flen);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            if (data !== want.data)
            begin
                $error("beat_data: expected %h, actual %h", want.data, data);
                errors++;
            end
            if (bytes !== want.bytes)
            begin
                $error("beat_bytes: expected %0d, actual %0d", want.bytes, bytes);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_beat: expected %0b, actual %0b", want.last, last);
                errors++;
            end
            if (flen !== want.flen)
            begin
                $error("frame_length: expected %0d, actual %0d", want.flen, flen);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        source_mac_we;
    logic [47:0] source_mac;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] frame_size;
    logic [1:0]  protocol;
    logic [7:0]  ttl;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] beat_data;
    logic [3:0]  beat_bytes;
    logic        last_beat;
    logic [15:0] frame_length;

    // Set for the closing phase: no idling on either side
    bit quiet;

    frame_header_ledger ledger;

    ipv4_test_frame_header_builder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .source_mac_we (source_mac_we),
        .source_mac    (source_mac),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .frame_size    (frame_size),
        .protocol      (protocol),
        .ttl           (ttl),
        .source_ip     (source_ip),
        .dest_ip       (dest_ip),
        .source_port   (source_port),
        .dest_port     (dest_port),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .beat_data     (beat_data),
        .beat_bytes    (beat_bytes),
        .last_beat     (last_beat),
        .frame_length  (frame_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run if the handshakes never complete.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[ipv4_test_frame_header_builder] ERROR");
        $finish;
    end

    function automatic pkt_desc_t make_desc(logic [15:0] fs, logic [1:0] proto,
                                            logic [7:0] hops, logic [31:0] sip,
                                            logic [31:0] dip, logic [15:0] sport,
                                            logic [15:0] dport);
        pkt_desc_t p;

        p.frame_size = fs;
        p.protocol   = proto;
        p.ttl        = hops;
        p.sip        = sip;
        p.dip        = dip;
        p.sport      = sport;
        p.dport      = dport;
        return p;
    endfunction

    // Realistic frame sizes, the 54-byte minimum, a share of short frames that
    // must be raised to the minimum, and many anywhere in the 16-bit range.
    function automatic pkt_desc_t random_desc();
        logic [15:0] fs;
        int          pick;

        pick = $urandom_range(0, 9);
        if (pick < 2)
            fs = 16'($urandom_range(0, 53));
        else if (pick == 2)
            fs = HDR_LEN;
        else if (pick < 6)
            fs = 16'($urandom_range(55, 1518));
        else
            fs = 16'($urandom_range(0, 65535));
        return make_desc(fs, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         32'($urandom), 32'($urandom),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endfunction

    // Present one description and hold it until the transfer. Called just
    // after a rising edge; returns just after the edge of the transfer, or
    // after the idle burst that follows it.
    task automatic send_desc(pkt_desc_t p);
        in_valid     <= 1'b1;
        frame_size   <= p.frame_size;
        protocol     <= p.protocol;
        ttl          <= p.ttl;
        source_ip    <= p.sip;
        dest_ip      <= p.dip;
        source_port  <= p.sport;
        dest_port    <= p.dport;
        do
            @(posedge clk);
        while (!in_ready);
        ledger.note_description(p);

        // Drop valid for a random burst now and then; otherwise keep it
        // high so the next description follows back to back.
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_random(int count);
        repeat (count)
            send_desc(random_desc());
    endtask

    // Drop valid, wait until every queued beat has come out, then let the
    // pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write source_mac while the block is idle, with a one-cycle pulse.
    task automatic write_source_mac(logic [47:0] value);
        drain();
        source_mac_we <= 1'b1;
        source_mac    <= value;
        ledger.set_mac(value);
        @(posedge clk);
        source_mac_we <= 1'b0;
    endtask

    // Beat monitor and receiver: check every beat transfer, and stall
    // out_ready in random bursts unless the run is in its quiet phase.
    initial
    begin : beat_receiver
        int stall_left;

        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                ledger.check_beat(beat_data, beat_bytes, last_beat, frame_length);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 6) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        ledger = new();
        quiet  = 1'b0;

        rst_n         <= 1'b0;
        source_mac_we <= 1'b0;
        source_mac    <= '0;
        in_valid      <= 1'b0;
        frame_size    <= '0;
        protocol      <= PROTO_TCP;
        ttl           <= '0;
        source_ip     <= '0;
        dest_ip       <= '0;
        source_port   <= '0;
        dest_port     <= '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with source_mac at its reset value: extreme sizes
        // around the 54-byte minimum, every protocol code including the
        // unused one, and all-zero / all-one addresses and ports.
        send_desc(make_desc(16'd0, PROTO_TCP, 8'd0, 32'h0, 32'h0, 16'h0, 16'h0));
        send_desc(make_desc(16'd53, PROTO_UDP, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            16'hFFFF, 16'hFFFF));
        send_desc(make_desc(16'd54, PROTO_ICMP, 8'd64, 32'hC0A8_0001, 32'hC0A8_00FE,
                            16'h1234, 16'h0050));
        send_desc(make_desc(16'd55, PROTO_UNUSED, 8'd128, 32'h0A00_0001, 32'h0A00_0002,
                            16'h4000, 16'h01BB));
        send_desc(make_desc(16'd65535, PROTO_TCP, 8'd255, 32'hFFFF_FFFF, 32'h0,
                            16'hFFFF, 16'h0));
        send_desc(make_desc(16'd65535, PROTO_UDP, 8'd1, 32'h0, 32'hFFFF_FFFF,
                            16'h0, 16'hFFFF));
        send_desc(make_desc(16'd65535, PROTO_ICMP, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            16'hFFFF, 16'hFFFF));
        send_desc(make_desc(16'd65535, PROTO_UNUSED, 8'd255, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        send_desc(make_desc(16'd0, PROTO_ICMP, 8'd0, 32'h0, 32'h0, 16'h0, 16'h0));
        send_desc(make_desc(16'd0, PROTO_UDP, 8'd0, 32'h0, 32'h0, 16'h0, 16'h0));
        send_desc(make_desc(16'd0, PROTO_UNUSED, 8'd0, 32'h0, 32'h0, 16'h0, 16'h0));
        send_desc(make_desc(16'd1518, PROTO_TCP, 8'hAA, 32'hAAAA_AAAA, 32'h5555_5555,
                            16'hAAAA, 16'h5555));
        send_desc(make_desc(16'd1518, PROTO_UDP, 8'h55, 32'h5555_5555, 32'hAAAA_AAAA,
                            16'h5555, 16'hAAAA));
        send_desc(make_desc(16'd60, PROTO_ICMP, 8'd32, 32'h7F00_0001, 32'h7F00_0001,
                            16'hBEEF, 16'hCAFE));
        send_desc(make_desc(16'd64, PROTO_UNUSED, 8'd200, 32'h8000_0000, 32'h0000_0001,
                            16'h8000, 16'h0001));
        send_desc(make_desc(16'd9000, PROTO_UDP, 8'd17, 32'hC633_6401, 32'hCB00_7101,
                            16'd53, 16'd5353));
        send_desc(make_desc(16'd53, PROTO_TCP, 8'd1, 32'h0000_0001, 32'h8000_0000,
                            16'h0001, 16'h8000));
        send_desc(make_desc(16'd1, PROTO_ICMP, 8'd128, 32'hFFFF_FFFE, 32'h0000_0001,
                            16'h0, 16'hFFFF));
        send_desc(make_desc(16'd54, PROTO_TCP, 8'd64, 32'hFF00_FF00, 32'h00FF_00FF,
                            16'hFFFF, 16'hFFFF));
        send_desc(make_desc(16'd35, PROTO_UDP, 8'd64, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                            16'h0F0F, 16'hF0F0));

        // Random phases, each under a different source MAC
        write_source_mac(48'hFFFF_FFFF_FFFF);
        send_random(100);

        write_source_mac({16'($urandom_range(0, 65535)), 32'($urandom)});
        send_random(100);

        write_source_mac(48'h0000_0000_0000);
        send_random(60);

        // Closing phase: no idling on either side, back-to-back transfers
        write_source_mac({16'($urandom_range(0, 65535)), 32'($urandom)});
        quiet = 1'b1;
        send_random(100);

        drain();
        if (ledger.errors == 0)
            $display("[ipv4_test_frame_header_builder] OK");
        else
            $display("[ipv4_test_frame_header_builder] ERROR");
        $finish;
    end

endmodule
